@@ sv/srbd_pkg.sv @@
// ----------------------------------------------------------------------------
// srbd_pkg
// Shared types and constants of the serial reply and button demultiplexer.
// ----------------------------------------------------------------------------
package srbd_pkg;

  // text store geometry
  localparam int STORE_DEPTH = 64;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // command queue depth, a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // button mask
  localparam int         NUM_BUTTONS = 5;
  localparam logic [7:0] BTN_LIMIT   = 8'd32;

  // characters of the button prefix, the prompt and line ends
  localparam logic [7:0] CH_K     = 8'h6b;
  localparam logic [7:0] CH_M     = 8'h6d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;

  // result kinds
  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_VALUE  = 2'd1,
    KIND_EMPTY  = 2'd2
  } kind_e;

  // command classes passed from front to back
  typedef enum logic {
    OP_TEXT,
    OP_BUTTON
  } cmd_op_e;

  // one classified request
  typedef struct packed {
    cmd_op_e                op;
    logic [7:0]             data;     // text byte, or new button mask
    logic [NUM_BUTTONS-1:0] changed;  // buttons whose level changed
    logic [1:0]             rep;      // prefix bytes to replay first
    logic                   wr_en;    // text byte is stored
    logic [ADDR_W-1:0]      addr;     // store address of the text byte
    logic                   reply;    // prompt completed by this byte
    logic [ADDR_W-1:0]      body;     // body length before the prompt
  } cmd_t;

endpackage

@@ sv/srbd_front.sv @@
// ----------------------------------------------------------------------------
// srbd_front
// Classifies each received byte: button prefix tracking, mask changes, store
// fill level and prompt detection. Issues one command per byte with work.
// ----------------------------------------------------------------------------
module srbd_front import srbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] rx_byte_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  typedef enum logic [1:0] {
    STG_NONE = 2'd0,
    STG_K    = 2'd1,
    STG_KM   = 2'd2,
    STG_KMD  = 2'd3
  } stage_e;

  stage_e                 stage_q, stage_d;
  logic [ADDR_W-1:0]      count_q, count_d;
  logic [NUM_BUTTONS-1:0] mask_q, mask_d;
  logic [2:0][7:0]        tail_q, tail_d;   // [0] newest stored byte

  logic                   consumed;
  logic                   push_c;
  logic [1:0]             rep;
  logic [ADDR_W-1:0]      cnt;
  logic [2:0][7:0]        tail_r;
  cmd_t                   cmd;

  // classification of the incoming byte
  always_comb begin
    stage_d  = stage_q;
    count_d  = count_q;
    mask_d   = mask_q;
    tail_d   = tail_q;
    consumed = 1'b0;
    push_c   = 1'b0;
    rep      = 2'd0;
    cmd      = '0;
    cmd.op   = OP_TEXT;
    cmd.data = rx_byte_i;

    // prefix matching while the store is empty or a prefix is pending
    if (count_q == '0 || stage_q != STG_NONE) begin
      unique case (stage_q)
        STG_NONE: begin
          if (rx_byte_i == CH_K) begin
            stage_d  = STG_K;
            consumed = 1'b1;
          end
        end
        STG_K: begin
          if (rx_byte_i == CH_M) begin
            stage_d  = STG_KM;
            consumed = 1'b1;
          end else begin
            rep = 2'd1;
          end
        end
        STG_KM: begin
          if (rx_byte_i == CH_DOT) begin
            stage_d  = STG_KMD;
            consumed = 1'b1;
          end else begin
            rep = 2'd2;
          end
        end
        STG_KMD: begin
          if (rx_byte_i < BTN_LIMIT) begin
            stage_d  = STG_NONE;
            consumed = 1'b1;
            if (rx_byte_i[NUM_BUTTONS-1:0] != mask_q) begin
              push_c      = 1'b1;
              cmd.op      = OP_BUTTON;
              cmd.changed = rx_byte_i[NUM_BUTTONS-1:0] ^ mask_q;
              mask_d      = rx_byte_i[NUM_BUTTONS-1:0];
            end
          end else begin
            rep = 2'd3;
          end
        end
        default: ;
      endcase
    end

    // broken prefix goes back into the empty store
    cnt    = count_q;
    tail_r = tail_q;
    if (rep != 2'd0) begin
      stage_d = STG_NONE;
      cnt     = ADDR_W'(rep);
      unique case (rep)
        2'd1:    tail_r = {tail_q[1], tail_q[0], CH_K};
        2'd2:    tail_r = {tail_q[0], CH_K, CH_M};
        default: tail_r = {CH_K, CH_M, CH_DOT};
      endcase
    end
    cmd.rep = rep;

    // text append, full store and prompt detection
    if (!consumed) begin
      push_c = 1'b1;
      if (cnt >= ADDR_W'(STORE_DEPTH - 1)) begin
        count_d   = '0;
        stage_d   = STG_NONE;
        cmd.wr_en = 1'b0;
        push_c    = (rep != 2'd0);
      end else begin
        cmd.wr_en = 1'b1;
        cmd.addr  = cnt;
        tail_d    = {tail_r[1], tail_r[0], rx_byte_i};
        if (cnt >= ADDR_W'(3) && tail_r[2] == CH_GT && tail_r[1] == CH_GT &&
            tail_r[0] == CH_GT && rx_byte_i == CH_SPACE) begin
          cmd.reply = 1'b1;
          cmd.body  = cnt - ADDR_W'(3);
          count_d   = '0;
        end else begin
          count_d = cnt + ADDR_W'(1);
        end
      end
    end
  end

  assign push_o = accept_i && push_c;
  assign cmd_o  = cmd;

  // classification state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= STG_NONE;
      count_q <= '0;
      mask_q  <= '0;
      tail_q  <= '0;
    end else if (accept_i) begin
      stage_q <= stage_d;
      count_q <= count_d;
      mask_q  <= mask_d;
      tail_q  <= tail_d;
    end
  end

  // a pending prefix only ever starts on an empty store
  a_prefix_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_q != STG_NONE) |-> (count_q == '0))
    else $error("prefix pending with text in store");

endmodule

@@ sv/srbd_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// srbd_cmd_queue
// Short command queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module srbd_cmd_queue import srbd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] fill_q;

  assign full_o  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign cmd_o   = entry_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - QCNT_W'(1);
      end
    end
  end

  // the front only pushes into a queue with room
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("push into full command queue");

endmodule

@@ sv/srbd_back.sv @@
// ----------------------------------------------------------------------------
// srbd_back
// Executes commands: owns the text store, writes text, scans a finished
// reply for its last line and drives the result register.
// ----------------------------------------------------------------------------
module srbd_back import srbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_byte_o,
  output logic [2:0] button_index_o,
  output logic       pressed_o,
  output logic       last_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_REPLAY,
    S_APPEND,
    S_TRIM_RD,
    S_TRIM_EX,
    S_LINE_RD,
    S_LINE_EX,
    S_EMIT_RD,
    S_EMIT_EX,
    S_EMPTY,
    S_BTN
  } state_e;

  state_e                 state_q;
  cmd_t                   cmd_q;
  logic [1:0]             rep_idx_q;
  logic [ADDR_W-1:0]      ptr_q;
  logic [ADDR_W-1:0]      end_q;
  logic [NUM_BUTTONS-1:0] btn_left_q;

  logic                   out_valid_q;
  kind_e                  kind_q;
  logic [7:0]             value_q;
  logic [2:0]             index_q;
  logic                   pressed_q;
  logic                   last_q;

  logic [7:0]             store_q [STORE_DEPTH];
  logic [7:0]             rdata_q;
  logic                   mem_we, mem_re;
  logic [ADDR_W-1:0]      mem_waddr, mem_raddr;
  logic [7:0]             mem_wdata;

  logic                   out_free;
  logic                   out_load;
  logic [2:0]             btn_idx;
  logic [NUM_BUTTONS-1:0] btn_rest;

  function automatic logic is_crlf(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic [2:0] lowest_bit(input logic [NUM_BUTTONS-1:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i);
    end
    return r;
  endfunction

  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = out_free &&
                    ((state_q == S_EMIT_EX) || (state_q == S_EMPTY) || (state_q == S_BTN));
  assign pop_o    = (state_q == S_IDLE) && !empty_i;
  assign btn_idx  = lowest_bit(btn_left_q);
  assign btn_rest = btn_left_q & (btn_left_q - NUM_BUTTONS'(1));

  // store port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ADDR_W'(rep_idx_q);
    mem_wdata = CH_DOT;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    unique case (state_q)
      S_REPLAY: begin
        mem_we = 1'b1;
        unique case (rep_idx_q)
          2'd0:    mem_wdata = CH_K;
          2'd1:    mem_wdata = CH_M;
          default: mem_wdata = CH_DOT;
        endcase
      end
      S_APPEND: begin
        mem_we    = cmd_q.wr_en;
        mem_waddr = cmd_q.addr;
        mem_wdata = cmd_q.data;
      end
      S_TRIM_RD: begin
        mem_re    = (end_q != '0);
        mem_raddr = end_q - ADDR_W'(1);
      end
      S_LINE_RD: begin
        mem_re    = (ptr_q != '0);
        mem_raddr = ptr_q - ADDR_W'(1);
      end
      S_EMIT_RD: begin
        mem_re = 1'b1;
      end
      default: ;
    endcase
  end

  // text store, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= store_q[mem_raddr];
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      rep_idx_q   <= '0;
      ptr_q       <= '0;
      end_q       <= '0;
      btn_left_q  <= '0;
      kind_q      <= KIND_BUTTON;
      value_q     <= '0;
      index_q     <= '0;
      pressed_q   <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            cmd_q      <= cmd_i;
            btn_left_q <= cmd_i.changed;
            rep_idx_q  <= '0;
            if (cmd_i.op == OP_BUTTON) begin
              state_q <= S_BTN;
            end else if (cmd_i.rep != 2'd0) begin
              state_q <= S_REPLAY;
            end else begin
              state_q <= S_APPEND;
            end
          end
        end
        // broken prefix bytes go in first
        S_REPLAY: begin
          rep_idx_q <= rep_idx_q + 2'd1;
          if (2'(rep_idx_q + 2'd1) == cmd_q.rep) begin
            state_q <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (cmd_q.reply) begin
            end_q   <= cmd_q.body;
            state_q <= S_TRIM_RD;
          end else begin
            state_q <= S_IDLE;
          end
        end
        // strip trailing line ends from the body
        S_TRIM_RD: begin
          state_q <= (end_q == '0) ? S_EMPTY : S_TRIM_EX;
        end
        S_TRIM_EX: begin
          if (is_crlf(rdata_q)) begin
            end_q   <= end_q - ADDR_W'(1);
            state_q <= S_TRIM_RD;
          end else begin
            ptr_q   <= end_q - ADDR_W'(1);
            state_q <= S_LINE_RD;
          end
        end
        // walk back to the start of the last line
        S_LINE_RD: begin
          state_q <= (ptr_q == '0) ? S_EMIT_RD : S_LINE_EX;
        end
        S_LINE_EX: begin
          if (is_crlf(rdata_q)) begin
            state_q <= S_EMIT_RD;
          end else begin
            ptr_q   <= ptr_q - ADDR_W'(1);
            state_q <= S_LINE_RD;
          end
        end
        // send the line byte by byte
        S_EMIT_RD: begin
          state_q <= S_EMIT_EX;
        end
        S_EMIT_EX: begin
          if (out_free) begin
            kind_q      <= KIND_VALUE;
            value_q     <= rdata_q;
            index_q     <= '0;
            pressed_q   <= 1'b0;
            last_q      <= (ptr_q + ADDR_W'(1) == end_q);
            ptr_q       <= ptr_q + ADDR_W'(1);
            state_q     <= (ptr_q + ADDR_W'(1) == end_q) ? S_IDLE : S_EMIT_RD;
          end
        end
        S_EMPTY: begin
          if (out_free) begin
            kind_q      <= KIND_EMPTY;
            value_q     <= '0;
            index_q     <= '0;
            pressed_q   <= 1'b0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        // one event per changed button, lowest first
        S_BTN: begin
          if (out_free) begin
            kind_q      <= KIND_BUTTON;
            value_q     <= '0;
            index_q     <= btn_idx;
            pressed_q   <= cmd_q.data[btn_idx];
            last_q      <= (btn_rest == '0);
            btn_left_q  <= btn_rest;
            if (btn_rest == '0) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign value_byte_o   = value_q;
  assign button_index_o = index_q;
  assign pressed_o      = pressed_q;
  assign last_o         = last_q;

  // emission never runs past the trimmed end
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT_EX) |-> (ptr_q < end_q))
    else $error("reply pointer beyond line end");

  // an empty reply is always the final result of its byte
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_EMPTY) |-> last_q)
    else $error("empty reply without last");

  // button sequencing always has an event left to send
  a_btn_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_BTN) |-> (btn_left_q != '0))
    else $error("button state with nothing to send");

endmodule

@@ sv/serial_reply_and_button_demux_unit.sv @@
// ----------------------------------------------------------------------------
// serial_reply_and_button_demux_unit
// Splits received serial bytes into button events and prompt-ended replies.
// ----------------------------------------------------------------------------
// Input channel: one received byte per request on rx_byte_i, taken when
// in_valid_i is high and in_stall_o is low. Output channel: result requests
// (kind_o, value_byte_o, button_index_o, pressed_o, last_o) under
// out_valid_o / out_stall_i; last_o marks the final result of one byte.
// The front classifies a byte in the cycle it is taken and queues any command
// it yields (two entries); in_stall_o is high only while that queue is full.
// The back runs one command at a time: a text byte writes each replayed
// prefix byte and then the byte itself unless the store is full; a mask
// change sends one event per changed button. A completed prompt then trims
// trailing line ends, scans back to the start of the last line and sends
// that line byte by byte, each step a store read followed by a check, since
// the single text store read port is registered.
// Results sit in an output register; while out_stall_i is high it holds its
// request and the back waits, but the front keeps taking bytes until the
// queue fills.
// Reset clears prefix, fill level, button mask and all control; the store
// contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module serial_reply_and_button_demux_unit import srbd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] value_byte_o,
  output logic [2:0] button_index_o,
  output logic       pressed_o,
  output logic       last_o
);

  logic accept;
  logic push;
  logic q_full, q_empty, pop;
  cmd_t cmd_in, cmd_out;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  // byte classification
  srbd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .cmd_o     (cmd_in)
  );

  // decoupling queue
  srbd_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .cmd_o   (cmd_out)
  );

  // command execution and results
  srbd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (q_empty),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .value_byte_o   (value_byte_o),
    .button_index_o (button_index_o),
    .pressed_o      (pressed_o),
    .last_o         (last_o)
  );

endmodule
